// File: sv/lrk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrk_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int CFG_W        = 7;
    localparam int ROW_W        = 64;
    localparam int IDX_OUT_W    = 6;
    localparam int SIZE_OUT_W   = 13;

    // Configuration register indexes
    localparam logic CFG_LINE_COUNT   = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_COPY_RD,
        DP_COPY_WR,
        DP_CHK_RD,
        DP_CHK_EV,
        DP_SCAN_NEXT,
        DP_POP_RD,
        DP_POP_EV,
        DP_REGION_END,
        DP_EMIT_RD,
        DP_EMIT_OUT
    } dp_op_t;

    // Cell selected for a check: the four neighbors in fill order, then scan and seed
    typedef enum logic [2:0] {
        TGT_UP,
        TGT_DOWN,
        TGT_LEFT,
        TGT_RIGHT,
        TGT_SCAN,
        TGT_SEED
    } tgt_t;

    typedef struct packed {
        dp_op_t op;
        tgt_t   tgt;
    } cmd_t;

    typedef struct packed {
        logic run_end;
        logic copy_last;
        logic push_done;
        logic stack_empty;
        logic nb_ok;
        logic scan_last;
        logic emit_last;
        logic has_best;
    } status_t;

endpackage

`default_nettype wire

// File: sv/lrk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lrk_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  lrk_pkg::status_t     status,
    output lrk_pkg::cmd_t        cmd,
    output logic                 busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR,
        S_SCAN_RD,
        S_SCAN_EV,
        S_POP_RD,
        S_POP_EV,
        S_NB_RD,
        S_NB_EV,
        S_SEED_RD,
        S_SEED_EV,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       pass_reg, pass_next;
    logic [1:0] nb_reg, nb_next;

    assign busy = (state_reg != S_IDLE);

    // Sequence the two fill passes and the output run
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        nb_next    = nb_reg;
        cmd.op     = lrk_pkg::DP_NOP;
        cmd.tgt    = lrk_pkg::tgt_t'({1'b0, nb_reg});
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = lrk_pkg::DP_LOAD;
                    if (status.run_end)
                    begin
                        state_next = S_COPY_RD;
                        pass_next  = 1'b0;
                    end
                end
            end
            S_COPY_RD:
            begin
                cmd.op     = lrk_pkg::DP_COPY_RD;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.op = lrk_pkg::DP_COPY_WR;
                if (!status.copy_last)
                    state_next = S_COPY_RD;
                else if (!pass_reg)
                    state_next = S_SCAN_RD;
                else if (status.has_best)
                    state_next = S_SEED_RD;
                else
                    state_next = S_EMIT_RD;
            end
            S_SCAN_RD:
            begin
                cmd.op     = lrk_pkg::DP_CHK_RD;
                cmd.tgt    = lrk_pkg::TGT_SCAN;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (status.push_done)
                begin
                    cmd.op     = lrk_pkg::DP_CHK_EV;
                    state_next = S_POP_RD;
                end
                else
                begin
                    cmd.op = lrk_pkg::DP_SCAN_NEXT;
                    if (status.scan_last)
                    begin
                        state_next = S_COPY_RD;
                        pass_next  = 1'b1;
                    end
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_POP_RD:
            begin
                if (!status.stack_empty)
                begin
                    cmd.op     = lrk_pkg::DP_POP_RD;
                    state_next = S_POP_EV;
                end
                else if (pass_reg)
                    state_next = S_EMIT_RD;
                else
                begin
                    cmd.op = lrk_pkg::DP_REGION_END;
                    if (status.scan_last)
                    begin
                        state_next = S_COPY_RD;
                        pass_next  = 1'b1;
                    end
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_POP_EV:
            begin
                cmd.op     = lrk_pkg::DP_POP_EV;
                nb_next    = 2'd0;
                state_next = S_NB_RD;
            end
            S_NB_RD:
            begin
                if (status.nb_ok)
                begin
                    cmd.op     = lrk_pkg::DP_CHK_RD;
                    state_next = S_NB_EV;
                end
                else if (nb_reg == 2'd3)
                    state_next = S_POP_RD;
                else
                    nb_next = nb_reg + 2'd1;
            end
            S_NB_EV:
            begin
                cmd.op = lrk_pkg::DP_CHK_EV;
                if (nb_reg == 2'd3)
                    state_next = S_POP_RD;
                else
                begin
                    nb_next    = nb_reg + 2'd1;
                    state_next = S_NB_RD;
                end
            end
            S_SEED_RD:
            begin
                cmd.op     = lrk_pkg::DP_CHK_RD;
                cmd.tgt    = lrk_pkg::TGT_SEED;
                state_next = S_SEED_EV;
            end
            S_SEED_EV:
            begin
                cmd.op     = lrk_pkg::DP_CHK_EV;
                state_next = S_POP_RD;
            end
            S_EMIT_RD:
            begin
                cmd.op     = lrk_pkg::DP_EMIT_RD;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                cmd.op     = lrk_pkg::DP_EMIT_OUT;
                state_next = status.emit_last ? S_IDLE : S_EMIT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            nb_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            nb_reg    <= nb_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/lrk_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lrk_dp #(
    parameter int MAX_ROWS = lrk_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lrk_pkg::DEF_MAX_COLS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [lrk_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [lrk_pkg::ROW_W-1:0]         row_bits,
    input  lrk_pkg::cmd_t                          cmd,
    output lrk_pkg::status_t                       status,
    output logic                                   result_strobe,
    output logic [lrk_pkg::ROW_W-1:0]              row_bits_out,
    output logic [lrk_pkg::IDX_OUT_W-1:0]          row_index,
    output logic [lrk_pkg::SIZE_OUT_W-1:0]         region_size,
    output logic                                   last_row
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int SPW   = $clog2(CELLS);
    localparam int SZW   = $clog2(CELLS + 1);

    // Memories: loaded grid, working grid, fill stack
    logic [MAX_COLS-1:0] g_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] w_mem [MAX_ROWS];
    logic [RW+CW-1:0]    s_mem [CELLS];

    logic [MAX_COLS-1:0] g_q_reg, w_q_reg;
    logic [RW+CW-1:0]    s_q_reg;

    logic [lrk_pkg::CFG_W-1:0] line_count_reg, column_count_reg;
    logic [RW-1:0]  rows_loaded_reg, last_row_reg, copy_idx_reg, emit_idx_reg;
    logic [RW-1:0]  sr_reg, cr_reg, br_reg, t_r_reg;
    logic [CW-1:0]  sc_reg, cc_reg, bc_reg, t_c_reg;
    logic [SZW-1:0] sp_reg, size_reg, best_reg;

    logic                      strobe_reg;
    logic [lrk_pkg::ROW_W-1:0] out_bits_reg;
    logic [RW-1:0]             out_idx_reg;
    logic                      out_last_reg;

    logic [RW:0]         lines, rows_inc;
    logic [CW:0]         cols, cols_m1;
    logic [MAX_COLS-1:0] colmask;
    logic [RW-1:0]       tr, g_addr, w_addr;
    logic [CW-1:0]       tc;
    logic                open_bit;
    logic                col_last;
    logic [SPW-1:0]      sp_wr, sp_rd;

    // Clamp the configured sizes
    always_comb
    begin
        if (line_count_reg == '0)
            lines = (RW+1)'(1);
        else if (32'(line_count_reg) > MAX_ROWS)
            lines = (RW+1)'(MAX_ROWS);
        else
            lines = (RW+1)'(line_count_reg);
        if (column_count_reg == '0)
            cols = (CW+1)'(1);
        else if (32'(column_count_reg) > MAX_COLS)
            cols = (CW+1)'(MAX_COLS);
        else
            cols = (CW+1)'(column_count_reg);
        cols_m1 = cols - (CW+1)'(1);
        for (int j = 0; j < MAX_COLS; j++)
            colmask[j] = (j < 32'(cols));
    end

    assign rows_inc = {1'b0, rows_loaded_reg} + (RW+1)'(1);
    assign col_last = ({1'b0, sc_reg} == cols_m1);
    assign sp_wr    = sp_reg[SPW-1:0];
    assign sp_rd    = SPW'(sp_reg - SZW'(1));

    // Select the cell under check
    always_comb
    begin
        tr = cr_reg;
        tc = cc_reg;
        case (cmd.tgt)
            lrk_pkg::TGT_UP:    tr = cr_reg - RW'(1);
            lrk_pkg::TGT_DOWN:  tr = cr_reg + RW'(1);
            lrk_pkg::TGT_LEFT:  tc = cc_reg - CW'(1);
            lrk_pkg::TGT_RIGHT: tc = cc_reg + CW'(1);
            lrk_pkg::TGT_SCAN:
            begin
                tr = sr_reg;
                tc = sc_reg;
            end
            lrk_pkg::TGT_SEED:
            begin
                tr = br_reg;
                tc = bc_reg;
            end
            default:
            begin
                tr = cr_reg;
                tc = cc_reg;
            end
        endcase
    end

    assign open_bit = !w_q_reg[t_c_reg];
    assign g_addr   = (cmd.op == lrk_pkg::DP_EMIT_RD) ? emit_idx_reg : copy_idx_reg;
    assign w_addr   = (cmd.op == lrk_pkg::DP_EMIT_RD) ? emit_idx_reg : tr;

    // Report status
    always_comb
    begin
        status.run_end     = (rows_inc >= lines);
        status.copy_last   = (copy_idx_reg == last_row_reg);
        status.push_done   = open_bit;
        status.stack_empty = (sp_reg == '0);
        status.scan_last   = (sr_reg == last_row_reg) && col_last;
        status.emit_last   = (emit_idx_reg == last_row_reg);
        status.has_best    = (best_reg != '0);
        case (cmd.tgt)
            lrk_pkg::TGT_UP:    status.nb_ok = (cr_reg != '0);
            lrk_pkg::TGT_DOWN:  status.nb_ok = (cr_reg != last_row_reg);
            lrk_pkg::TGT_LEFT:  status.nb_ok = (cc_reg != '0);
            lrk_pkg::TGT_RIGHT: status.nb_ok = (cc_reg != CW'(MAX_COLS - 1));
            default:            status.nb_ok = 1'b1;
        endcase
    end

    // Memory writes and registered reads
    always_ff @(posedge clk)
    begin
        g_q_reg <= g_mem[g_addr];
        w_q_reg <= w_mem[w_addr];
        s_q_reg <= s_mem[sp_rd];
        if (cmd.op == lrk_pkg::DP_LOAD)
            g_mem[rows_loaded_reg] <= row_bits[MAX_COLS-1:0];
        if (cmd.op == lrk_pkg::DP_COPY_WR)
            w_mem[copy_idx_reg] <= g_q_reg | ~colmask;
        if (cmd.op == lrk_pkg::DP_CHK_EV && open_bit)
        begin
            w_mem[t_r_reg] <= w_q_reg | (MAX_COLS'(1) << t_c_reg);
            s_mem[sp_wr]   <= {t_r_reg, t_c_reg};
        end
    end

    // Payload registers for checks, pops and results
    always_ff @(posedge clk)
    begin
        if (cmd.op == lrk_pkg::DP_CHK_RD)
        begin
            t_r_reg <= tr;
            t_c_reg <= tc;
        end
        if (cmd.op == lrk_pkg::DP_POP_EV)
        begin
            cr_reg <= s_q_reg[RW+CW-1:CW];
            cc_reg <= s_q_reg[CW-1:0];
        end
        if (cmd.op == lrk_pkg::DP_EMIT_OUT)
        begin
            // Clear only kept cells; columns above the grid read solid
            out_bits_reg <= ~(lrk_pkg::ROW_W'(w_q_reg & ~g_q_reg & colmask));
            out_idx_reg  <= emit_idx_reg;
            out_last_reg <= (emit_idx_reg == last_row_reg);
        end
    end

    // Control state: config, counters, stack pointer, best region
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg   <= lrk_pkg::CFG_W'(64);
            column_count_reg <= lrk_pkg::CFG_W'(64);
            rows_loaded_reg  <= '0;
            last_row_reg     <= '0;
            copy_idx_reg     <= '0;
            emit_idx_reg     <= '0;
            sr_reg           <= '0;
            sc_reg           <= '0;
            br_reg           <= '0;
            bc_reg           <= '0;
            sp_reg           <= '0;
            size_reg         <= '0;
            best_reg         <= '0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            strobe_reg <= (cmd.op == lrk_pkg::DP_EMIT_OUT);
            if (cfg_we)
            begin
                if (cfg_index == lrk_pkg::CFG_LINE_COUNT)
                    line_count_reg <= cfg_data;
                else
                    column_count_reg <= cfg_data;
            end
            case (cmd.op)
                lrk_pkg::DP_LOAD:
                begin
                    if (rows_inc >= lines)
                    begin
                        last_row_reg    <= rows_loaded_reg;
                        rows_loaded_reg <= '0;
                        copy_idx_reg    <= '0;
                        emit_idx_reg    <= '0;
                        sr_reg          <= '0;
                        sc_reg          <= '0;
                        sp_reg          <= '0;
                        size_reg        <= '0;
                        best_reg        <= '0;
                    end
                    else
                        rows_loaded_reg <= rows_inc[RW-1:0];
                end
                lrk_pkg::DP_COPY_WR:
                begin
                    copy_idx_reg <= (copy_idx_reg == last_row_reg) ? '0
                                                                   : copy_idx_reg + RW'(1);
                end
                lrk_pkg::DP_CHK_EV:
                begin
                    if (open_bit)
                        sp_reg <= sp_reg + SZW'(1);
                end
                lrk_pkg::DP_POP_RD:
                begin
                    sp_reg <= sp_reg - SZW'(1);
                end
                lrk_pkg::DP_POP_EV:
                begin
                    size_reg <= size_reg + SZW'(1);
                end
                lrk_pkg::DP_SCAN_NEXT, lrk_pkg::DP_REGION_END:
                begin
                    if (cmd.op == lrk_pkg::DP_REGION_END)
                    begin
                        size_reg <= '0;
                        if (size_reg > best_reg)
                        begin
                            best_reg <= size_reg;
                            br_reg   <= sr_reg;
                            bc_reg   <= sc_reg;
                        end
                    end
                    if (col_last)
                    begin
                        sc_reg <= '0;
                        sr_reg <= sr_reg + RW'(1);
                    end
                    else
                        sc_reg <= sc_reg + CW'(1);
                end
                lrk_pkg::DP_EMIT_OUT:
                begin
                    emit_idx_reg <= emit_idx_reg + RW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign row_bits_out  = out_bits_reg;
    assign row_index     = lrk_pkg::IDX_OUT_W'(out_idx_reg);
    assign region_size   = lrk_pkg::SIZE_OUT_W'(best_reg);
    assign last_row      = out_last_reg;

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= CELLS)
        else $error("fill stack overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lrk_pkg::DP_POP_RD) |-> (sp_reg != '0))
        else $error("pop from empty fill stack");
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_row) |=> !result_strobe)
        else $error("result after last row");
    a_emit_empty_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lrk_pkg::DP_EMIT_RD) |-> (sp_reg == '0))
        else $error("output started with fill pending");
`endif

endmodule

`default_nettype wire

// File: sv/largest_region_keeper_top.sv
// Loading: one row per cycle while busy is low; a row that does not end the grid
// gives no result. The row that ends the grid starts labeling: two grid copies,
// a raster scan of the cells, and per open cell in each fill pass one pop plus
// four neighbor checks on the working grid memory.
// Output: one result_strobe per row; the receiver cannot stall.
// Reset (rst_n, async low) clears control state; grid and stack memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module largest_region_keeper_top #(
    parameter int MAX_ROWS = lrk_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lrk_pkg::DEF_MAX_COLS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [lrk_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [lrk_pkg::ROW_W-1:0]         row_bits,
    output logic                                   result_strobe,
    output logic [lrk_pkg::ROW_W-1:0]              row_bits_out,
    output logic [lrk_pkg::IDX_OUT_W-1:0]          row_index,
    output logic [lrk_pkg::SIZE_OUT_W-1:0]         region_size,
    output logic                                   last_row
);

    lrk_pkg::cmd_t    cmd;
    lrk_pkg::status_t status;

    lrk_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lrk_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .row_bits      (row_bits),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .row_bits_out  (row_bits_out),
        .row_index     (row_index),
        .region_size   (region_size),
        .last_row      (last_row)
    );

endmodule

`default_nettype wire

// File: sim/tb_largest_region_keeper_top.sv
`timescale 1ns / 1ps

module tb_largest_region_keeper_top;

    localparam int GRID_ROWS  = 64;
    localparam int GRID_COLS  = 64;
    localparam int CYCLE_CAP  = 3000000;
    localparam int TAIL_WAIT  = 200;

    // Row density styles for generated grids
    localparam int DENS_OPEN   = 0;
    localparam int DENS_SPARSE = 1;
    localparam int DENS_HALF   = 2;
    localparam int DENS_DENSE  = 3;
    localparam int DENS_SOLID  = 4;

    typedef struct {
        logic [lrk_pkg::ROW_W-1:0]      bits;
        logic [lrk_pkg::IDX_OUT_W-1:0]  idx;
        logic [lrk_pkg::SIZE_OUT_W-1:0] size;
        logic                           last;
    } kept_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [lrk_pkg::CFG_W-1:0]      cfg_data;
    logic [lrk_pkg::ROW_W-1:0]      row_bits;
    logic                           result_strobe;
    logic [lrk_pkg::ROW_W-1:0]      row_bits_out;
    logic [lrk_pkg::IDX_OUT_W-1:0]  row_index;
    logic [lrk_pkg::SIZE_OUT_W-1:0] region_size;
    logic                           last_row;

    largest_region_keeper_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .row_bits      (row_bits),
        .result_strobe (result_strobe),
        .row_bits_out  (row_bits_out),
        .row_index     (row_index),
        .region_size   (region_size),
        .last_row      (last_row)
    );

    // Pending input rows and expected filtered rows
    logic [lrk_pkg::ROW_W-1:0] row_q[$];
    kept_row_t                 kept_q[$];

    // Predictor state
    logic [lrk_pkg::ROW_W-1:0] grid_m[GRID_ROWS];
    int               region_id[GRID_ROWS*GRID_COLS];
    int               fill_stk[GRID_ROWS*GRID_COLS];
    int               fill_sp;
    int               rows_held;
    int               line_reg;
    int               col_reg;
    int               cur_label;

    int  err_cnt;
    int  cycle_cnt;
    int  gap_left;
    int  sent_cnt;
    bit  calm;

    always #5 clk = ~clk;

    function automatic int clamp_to(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Mark an open, unlabeled cell with the current label and stack it
    function automatic void mark_cell(int r, int c);
        int idx;
        idx = r * GRID_COLS + c;
        if (grid_m[r][c] != 1'b0 || region_id[idx] != 0) return;
        region_id[idx] = cur_label;
        fill_stk[fill_sp] = idx;
        fill_sp++;
    endfunction

    // Load one row; on the row that ends the grid, label and queue the output rows
    function automatic void absorb_row(logic [lrk_pkg::ROW_W-1:0] r_in);
        int        lines, cols, rows, sz, best_lbl, best_sz, idx, cr, cc;
        kept_row_t k;
        lines = clamp_to(line_reg, GRID_ROWS);
        cols  = clamp_to(col_reg, GRID_COLS);
        if (rows_held >= GRID_ROWS) rows_held = GRID_ROWS - 1;
        grid_m[rows_held] = r_in;
        rows_held++;
        if (rows_held < lines) return;
        rows = rows_held;
        rows_held = 0;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                region_id[r * GRID_COLS + c] = 0;
        cur_label = 1;
        best_lbl = 0;
        best_sz = 0;
        fill_sp = 0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (grid_m[r][c] != 1'b0 || region_id[r * GRID_COLS + c] != 0) continue;
                sz = 0;
                mark_cell(r, c);
                while (fill_sp > 0) begin
                    fill_sp--;
                    idx = fill_stk[fill_sp];
                    cr = idx / GRID_COLS;
                    cc = idx % GRID_COLS;
                    sz++;
                    if (cr > 0) mark_cell(cr - 1, cc);
                    if (cr + 1 < rows) mark_cell(cr + 1, cc);
                    if (cc > 0) mark_cell(cr, cc - 1);
                    if (cc + 1 < cols) mark_cell(cr, cc + 1);
                end
                if (sz > best_sz) begin
                    best_sz = sz;
                    best_lbl = cur_label;
                end
                cur_label++;
            end
        end
        for (int r = 0; r < rows; r++) begin
            k.bits = '1;
            if (best_lbl != 0)
                for (int c = 0; c < cols; c++)
                    if (region_id[r * GRID_COLS + c] == best_lbl) k.bits[c] = 1'b0;
            k.idx  = r[lrk_pkg::IDX_OUT_W-1:0];
            k.size = best_sz[lrk_pkg::SIZE_OUT_W-1:0];
            k.last = (r + 1 == rows);
            kept_q.push_back(k);
        end
    endfunction

    function automatic logic [lrk_pkg::ROW_W-1:0] make_row(int dens);
        logic [lrk_pkg::ROW_W-1:0] a, b, c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (dens)
            DENS_OPEN:   return '0;
            DENS_SPARSE: return a & b & c;
            DENS_HALF:   return a;
            DENS_DENSE:  return a | b;
            default:     return '1;
        endcase
    endfunction

    // Driver: present rows from the queue, with random idle bursts
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start    <= 1'b0;
            row_bits <= '0;
        end
        else begin : drive_blk
            logic go;
            go = start;
            if (start && !busy) begin
                absorb_row(row_bits);
                go = 1'b0;
                if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 5);
            end
            if (!go) begin
                if (gap_left > 0) gap_left--;
                else if (row_q.size() > 0) begin
                    row_bits <= row_q.pop_front();
                    sent_cnt++;
                    go = 1'b1;
                end
            end
            start <= go;
        end
    end

    // Monitor: compare each transfer with the oldest expected row
    always @(posedge clk) begin
        if (rst_n && result_strobe) begin : check_blk
            kept_row_t k;
            if (kept_q.size() == 0) begin
                $display("%0t: unexpected result row %0d, bits %h", $time, row_index,
                         row_bits_out);
                err_cnt++;
            end
            else begin
                k = kept_q.pop_front();
                if (row_bits_out !== k.bits) begin
                    $display("%0t: row_bits_out expected %h actual %h", $time, k.bits,
                             row_bits_out);
                    err_cnt++;
                end
                if (row_index !== k.idx) begin
                    $display("%0t: row_index expected %0d actual %0d", $time, k.idx,
                             row_index);
                    err_cnt++;
                end
                if (region_size !== k.size) begin
                    $display("%0t: region_size expected %0d actual %0d", $time, k.size,
                             region_size);
                    err_cnt++;
                end
                if (last_row !== k.last) begin
                    $display("%0t: last_row expected %0b actual %0b", $time, k.last,
                             last_row);
                    err_cnt++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold until all rows are sent and every expected row has come out;
    // sample away from the driving edge so the driver's updates are settled
    task automatic drain();
        while (row_q.size() != 0 || start || busy || kept_q.size() != 0) @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[lrk_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lrk_pkg::CFG_LINE_COUNT) line_reg = val & 8'h7f;
        else col_reg = val & 8'h7f;
    endtask

    task automatic set_shape(int lines, int cols);
        drain();
        write_reg(lrk_pkg::CFG_LINE_COUNT, lines);
        write_reg(lrk_pkg::CFG_COLUMN_COUNT, cols);
    endtask

    task automatic queue_grid(int n, int dens);
        for (int i = 0; i < n; i++) row_q.push_back(make_row(dens));
    endtask

    initial begin
        int lines, cols, grids, dens;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = lrk_pkg::CFG_LINE_COUNT;
        cfg_data = '0;
        err_cnt = 0;
        cycle_cnt = 0;
        gap_left = 0;
        sent_cnt = 0;
        calm = 0;
        fill_sp = 0;
        rows_held = 0;
        line_reg = 64;
        col_reg = 64;
        cur_label = 1;
        for (int r = 0; r < GRID_ROWS; r++) grid_m[r] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Single-cell grids, open and solid; zero registers act as one
        set_shape(1, 1);
        row_q.push_back('0);
        row_q.push_back('1);
        set_shape(0, 0);
        row_q.push_back(64'hffff_ffff_ffff_fffe);
        // Two full-width rows: all open, then all solid
        set_shape(2, 64);
        row_q.push_back('0);
        row_q.push_back('0);
        row_q.push_back('1);
        row_q.push_back('1);
        // Tie between two equal regions: the first in raster order is kept
        set_shape(2, 7);
        row_q.push_back(64'hffff_ffff_ffff_ff08);
        row_q.push_back(64'h0000_0000_0000_0008);
        // Checkerboard: every region is a single cell
        set_shape(3, 8);
        row_q.push_back(64'h5555_5555_5555_5555);
        row_q.push_back(64'haaaa_aaaa_aaaa_aaaa);
        row_q.push_back(64'h5555_5555_5555_5555);
        // Lower line_count mid-load: the run covers every loaded row
        set_shape(4, 8);
        row_q.push_back(64'h0000_0000_0000_0010);
        row_q.push_back(64'h0000_0000_0000_00f0);
        row_q.push_back(64'h0000_0000_0000_0000);
        drain();
        write_reg(lrk_pkg::CFG_LINE_COUNT, 2);
        row_q.push_back(64'h0000_0000_0000_0081);
        // Oversized registers act as the maximum grid
        set_shape(127, 127);
        queue_grid(64, DENS_SPARSE);
        set_shape(64, 64);
        queue_grid(64, DENS_HALF);

        // Random shapes, mostly small grids with varied density
        while (sent_cnt + row_q.size() < 260) begin
            if ($urandom_range(0, 9) == 0) lines = $urandom_range(9, 40);
            else lines = $urandom_range(1, 8);
            case ($urandom_range(0, 7))
                0: cols = 0;
                1: cols = 127;
                2: cols = 64;
                default: cols = $urandom_range(1, 64);
            endcase
            set_shape(lines, cols);
            if (sent_cnt > 220) calm = 1;
            grids = $urandom_range(1, 3);
            for (int g = 0; g < grids; g++) begin
                dens = $urandom_range(0, 9);
                if (dens > DENS_SOLID) dens = (dens < 8) ? DENS_SPARSE : DENS_HALF;
                queue_grid(clamp_to(lines, GRID_ROWS), dens);
            end
        end

        drain();
        repeat (TAIL_WAIT) @(posedge clk);
        if (err_cnt == 0 && kept_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
